// ===== hdl/ksx_pkg.sv =====
// Package for the kinematic successor expander: types, constants, CORDIC table.
// No dependencies; used by every module of the block.
package ksx_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int ANGLE_BITS      = 16;
  localparam int TRIG_ITER_DEF   = 16;
  localparam int ATAN_LEN        = 24;
  localparam int ANGLE_SHIFT     = 32 - ANGLE_BITS;

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [31:0] UNIT30       = 32'sd1073741824;

  // turning step below 1000 rad is taken as straight
  localparam longint STRAIGHT_LIM = (64'd1000000000 << ANGLE_BITS);
  localparam longint STRAIGHT_MAX = (STRAIGHT_LIM - 1) / 6283185;

  localparam logic [2:0] PRIM_STRAIGHT = 3'd0;
  localparam logic [2:0] PRIM_LEFT     = 3'd1;
  localparam logic [2:0] PRIM_REV      = 3'd3;
  localparam logic [2:0] PRIM_MAX      = 3'd5;

  localparam logic [7:0] REG_STEP     = 8'd0;
  localparam logic [7:0] REG_RADIUS   = 8'd1;
  localparam logic [7:0] REG_ANGLE    = 8'd2;
  localparam logic [7:0] REG_PEN_TURN = 8'd3;
  localparam logic [7:0] REG_PEN_REV  = 8'd4;
  localparam logic [7:0] REG_PEN_DIR  = 8'd5;
  localparam logic [7:0] REG_GRID_W   = 8'd6;
  localparam logic [7:0] REG_GRID_H   = 8'd7;

  typedef struct packed {
    logic [31:0] step;
    logic [31:0] radius;
    logic [14:0] angle;
    logic [15:0] pen_turn;
    logic [15:0] pen_rev;
    logic [15:0] pen_dir;
    logic [15:0] grid_w;
    logic [15:0] grid_h;
  } ksx_cfg_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] nh;
    logic [31:0] cost;
    logic        rev;
    logic        straight;
    logic        left;
    logic        t_turn;
    logic        t_dir;
  } ksx_item_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic               neg;
  } ksx_rot_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/kinematic_successor_expander.sv =====
// Kinematic successor expander: hybrid A* bicycle-model successor pose and cost.
// Throughput one beat per cycle; the whole pipe advances when the output register
// is empty or its beat is taken, so a stalled output holds every stage.
// Synchronous reset clears stage valid bits and loads the register defaults.
// Depends on ksx_pkg, ksx_cell, ksx_finish.
module kinematic_successor_expander #(
  parameter int TRIG_ITERATIONS = ksx_pkg::TRIG_ITER_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[31:0], pos_y[63:32], heading[79:64], path_cost[111:80],
  // primitive_req[114:112], previous_primitive[117:115], zero pad
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // next_x[31:0], next_y[63:32], next_heading[79:64], next_cost[111:80],
  // on_grid[112], cost_saturated[113], zero pad
  output logic [119:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ksx_pkg::*;

  ksx_cfg_t cfg;
  logic     en;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step     <= 32'd46324;
      cfg.radius   <= 32'd393216;
      cfg.angle    <= 15'd1229;
      cfg.pen_turn <= 16'd269;
      cfg.pen_rev  <= 16'd512;
      cfg.pen_dir  <= 16'd512;
      cfg.grid_w   <= 16'd1024;
      cfg.grid_h   <= 16'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP:     cfg.step     <= cfg_data;
        REG_RADIUS:   cfg.radius   <= cfg_data;
        REG_ANGLE:    cfg.angle    <= cfg_data[14:0];
        REG_PEN_TURN: cfg.pen_turn <= cfg_data[15:0];
        REG_PEN_REV:  cfg.pen_rev  <= cfg_data[15:0];
        REG_PEN_DIR:  cfg.pen_dir  <= cfg_data[15:0];
        REG_GRID_W:   cfg.grid_w   <= cfg_data[15:0];
        REG_GRID_H:   cfg.grid_h   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // fold the angle into the right half-plane before rotating
  function automatic ksx_rot_t prerot(input logic [31:0] ang);
    ksx_rot_t   r;
    logic [31:0] t, a;
    t     = ang + 32'h40000000;
    r.neg = t[31];
    a     = t[31] ? ang - 32'h80000000 : ang;
    r.x   = CORDIC_START;
    r.y   = 34'sd0;
    r.z   = {a[31], a};
    return r;
  endfunction

  // entry decode
  logic [31:0] in_px, in_py, in_cost;
  logic [15:0] in_hd;
  logic [2:0]  req, prev, turn;
  logic        rev, prev_rev, straight, pos_beta;
  logic [15:0] ta;
  logic [31:0] h32, b32, hb;
  ksx_item_t   e_item;

  assign in_px    = s_axis_tdata[31:0];
  assign in_py    = s_axis_tdata[63:32];
  assign in_hd    = s_axis_tdata[79:64];
  assign in_cost  = s_axis_tdata[111:80];
  assign req      = (s_axis_tdata[114:112] > PRIM_MAX) ? PRIM_MAX : s_axis_tdata[114:112];
  assign prev     = (s_axis_tdata[117:115] > PRIM_MAX) ? PRIM_MAX : s_axis_tdata[117:115];
  assign rev      = req >= PRIM_REV;
  assign prev_rev = prev >= PRIM_REV;
  assign turn     = rev ? req - PRIM_REV : req;
  assign ta       = {1'b0, cfg.angle};
  assign straight = (turn == PRIM_STRAIGHT) || ({48'd0, ta} <= 64'(STRAIGHT_MAX));
  assign pos_beta = (turn == PRIM_LEFT) != rev;
  assign h32      = {in_hd, {ANGLE_SHIFT{1'b0}}};
  assign b32      = {ta, {ANGLE_SHIFT{1'b0}}};
  assign hb       = pos_beta ? h32 + b32 : h32 - b32;

  always_comb begin
    e_item.px       = in_px;
    e_item.py       = in_py;
    e_item.cost     = in_cost;
    e_item.rev      = rev;
    e_item.straight = straight;
    e_item.left     = turn == PRIM_LEFT;
    e_item.t_turn   = req != prev;
    e_item.t_dir    = (req != prev) && (rev != prev_rev);
    if (straight) begin
      e_item.nh = in_hd;
    end else begin
      e_item.nh = pos_beta ? in_hd + ta : in_hd - ta;
    end
  end

  // chain: entry register, then one cell per CORDIC rotation
  logic      cv [TRIG_ITERATIONS+1];
  ksx_item_t ci [TRIG_ITERATIONS+1];
  ksx_rot_t  ca [TRIG_ITERATIONS+1];
  ksx_rot_t  cb [TRIG_ITERATIONS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ci[0] <= e_item;
      ca[0] <= prerot(h32);
      cb[0] <= prerot(hb);
    end
  end

  for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_cell
    ksx_cell #(.ITER(g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (cv[g]),
      .in_item  (ci[g]),
      .in_a     (ca[g]),
      .in_b     (cb[g]),
      .out_valid(cv[g+1]),
      .out_item (ci[g+1]),
      .out_a    (ca[g+1]),
      .out_b    (cb[g+1])
    );
  end

  ksx_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_valid (cv[TRIG_ITERATIONS]),
    .in_item  (ci[TRIG_ITERATIONS]),
    .in_a     (ca[TRIG_ITERATIONS]),
    .in_b     (cb[TRIG_ITERATIONS]),
    .out_valid(m_axis_tvalid),
    .out_data (m_axis_tdata)
  );

endmodule

// ===== hdl/ksx_cell.sv =====
// One CORDIC rotation cell of the chain, two angle channels plus item sidecar.
// Depends on ksx_pkg.
module ksx_cell #(
  parameter int ITER = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  ksx_pkg::ksx_item_t in_item,
  input  ksx_pkg::ksx_rot_t  in_a,
  input  ksx_pkg::ksx_rot_t  in_b,
  output logic              out_valid,
  output ksx_pkg::ksx_item_t out_item,
  output ksx_pkg::ksx_rot_t  out_a,
  output ksx_pkg::ksx_rot_t  out_b
);
  import ksx_pkg::*;

  localparam logic signed [32:0] ATAN = $signed({1'b0, atan_turn(ITER)});

  function automatic ksx_rot_t rotate(input ksx_rot_t r);
    ksx_rot_t o;
    o = r;
    if (!r.z[32]) begin
      o.x = r.x - (r.y >>> ITER);
      o.y = r.y + (r.x >>> ITER);
      o.z = r.z - ATAN;
    end else begin
      o.x = r.x + (r.y >>> ITER);
      o.y = r.y - (r.x >>> ITER);
      o.z = r.z + ATAN;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= in_item;
      out_a    <= rotate(in_a);
      out_b    <= rotate(in_b);
    end
  end

endmodule

// ===== hdl/ksx_finish.sv =====
// Back end: sin/cos fix-up, arc and straight-line products, pose update, cost penalties, grid test.
// Depends on ksx_pkg; fed by the end of the CORDIC cell chain.
module ksx_finish (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  ksx_pkg::ksx_cfg_t  cfg,
  input  logic              in_valid,
  input  ksx_pkg::ksx_item_t in_item,
  input  ksx_pkg::ksx_rot_t  in_a,
  input  ksx_pkg::ksx_rot_t  in_b,
  output logic              out_valid,
  output logic [119:0]      out_data  // next_x, next_y, next_heading, next_cost, on_grid, cost_saturated
);
  import ksx_pkg::*;

  function automatic logic signed [31:0] fix(input logic signed [33:0] v, input logic neg);
    logic signed [34:0] t;
    t = neg ? -{v[33], v} : {v[33], v};
    if (t > 35'sd1073741824) return UNIT30;
    if (t < -35'sd1073741824) return -UNIT30;
    return t[31:0];
  endfunction

  function automatic logic [32:0] factor(input logic [31:0] acc, input logic [15:0] f);
    logic [48:0] p;
    logic [40:0] s;
    p = 49'(acc) * 49'(f) + 49'd128;
    s = p[48:8];
    if (s > 41'h0FFFFFFFF) return {1'b1, 32'hFFFFFFFF};
    return {1'b0, s[31:0]};
  endfunction

  // stage 1
  logic              v1;
  ksx_item_t         it1;
  logic signed [31:0] sa1, ca1, sb1, cb1;
  logic [31:0]       acc1;
  logic              sat1;
  logic [32:0]       f1;

  assign f1 = in_item.t_turn ? factor(cfg.step, cfg.pen_turn) : {1'b0, cfg.step};

  always_ff @(posedge clk) begin
    if (en) begin
      it1  <= in_item;
      ca1  <= fix(in_a.x, in_a.neg);
      sa1  <= fix(in_a.y, in_a.neg);
      cb1  <= fix(in_b.x, in_b.neg);
      sb1  <= fix(in_b.y, in_b.neg);
      acc1 <= f1[31:0];
      sat1 <= f1[32];
    end
  end

  // stage 2: operand select
  logic              v2;
  ksx_item_t         it2;
  logic signed [32:0] mul2, opx2, opy2;
  logic [31:0]       acc2;
  logic              sat2;
  logic [32:0]       f2;
  logic signed [32:0] d_s, r_s;

  assign f2  = it1.rev ? factor(acc1, cfg.pen_rev) : {1'b0, acc1};
  assign d_s = it1.rev ? -$signed({1'b0, cfg.step}) : $signed({1'b0, cfg.step});
  assign r_s = it1.left ? $signed({1'b0, cfg.radius}) : -$signed({1'b0, cfg.radius});

  always_ff @(posedge clk) begin
    if (en) begin
      it2 <= it1;
      if (it1.straight) begin
        mul2 <= d_s;
        opx2 <= {ca1[31], ca1};
        opy2 <= {sa1[31], sa1};
      end else begin
        mul2 <= r_s;
        opx2 <= {sb1[31], sb1} - {sa1[31], sa1};
        opy2 <= {ca1[31], ca1} - {cb1[31], cb1};
      end
      acc2 <= f2[31:0];
      sat2 <= sat1 | f2[32];
    end
  end

  // stage 3: products
  logic              v3;
  ksx_item_t         it3;
  logic signed [65:0] prx3, pry3;
  logic [31:0]       acc3;
  logic              sat3;
  logic [32:0]       f3;

  assign f3 = it2.t_dir ? factor(acc2, cfg.pen_dir) : {1'b0, acc2};

  always_ff @(posedge clk) begin
    if (en) begin
      it3  <= it2;
      prx3 <= mul2 * opx2;
      pry3 <= mul2 * opy2;
      acc3 <= f3[31:0];
      sat3 <= sat2 | f3[32];
    end
  end

  // stage 4: pose and cost sums
  logic              v4;
  logic [31:0]       px4, py4, cost4;
  logic [15:0]       nh4;
  logic              sat4;
  logic signed [65:0] rx, ry;
  logic [32:0]       csum;

  assign rx   = prx3 + 66'sd536870912;
  assign ry   = pry3 + 66'sd536870912;
  assign csum = {1'b0, it3.cost} + {1'b0, acc3};

  always_ff @(posedge clk) begin
    if (en) begin
      px4   <= it3.px + rx[61:30];
      py4   <= it3.py + ry[61:30];
      nh4   <= it3.nh;
      cost4 <= csum[32] ? 32'hFFFFFFFF : csum[31:0];
      sat4  <= sat3 | csum[32];
    end
  end

  // stage 5: grid test into output register
  logic [47:0] limx, limy;
  logic        grid;

  assign limx = {16'd0, cfg.grid_w, {COORD_FRAC_BITS{1'b0}}};
  assign limy = {16'd0, cfg.grid_h, {COORD_FRAC_BITS{1'b0}}};
  assign grid = !px4[31] && ({16'd0, px4} < limx) && !py4[31] && ({16'd0, py4} < limy);

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= {6'd0, sat4, grid, cost4, nh4, py4, px4};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

endmodule
